// ----- rtl/core/multi_channel_strobe_timer_core_defines.svh -----
// assertion macros shared by the strobe timer rtl
`ifndef MULTI_CHANNEL_STROBE_TIMER_CORE_DEFINES_SVH
`define MULTI_CHANNEL_STROBE_TIMER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MCST_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcst assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define MCST_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcst assertion failed");

`endif

// ----- rtl/core/mcst_pkg.sv -----
// types, constants and widths for the strobe timer
package mcst_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_W   = 2;
  localparam int CMP_W    = (CH_IDX_W > CHAN_W) ? CH_IDX_W : CHAN_W;
  localparam int DRN_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CNT_W    = 16;
  localparam int DUTY_W   = 7;
  localparam int MODE_W   = 2;
  localparam int KIND_W   = 2;
  localparam int PROD_W   = CNT_W + DUTY_W;

  // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for every x below 2**PROD_W
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
  localparam int QUOT_W      = PROD_W + RECIP_W;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOW    = 2'd0,
    KIND_HIGH   = 2'd1,
    KIND_TOGGLE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_TICK  = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_SHIFT = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [CHAN_W-1:0]  channel;
    logic [CNT_W-1:0]   duration;
    logic [CNT_W-1:0]   period;
    logic [CNT_W-1:0]   pulse;
  } cell_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] channel;
    kind_t             kind;
  } ev_t;

endpackage

// ----- rtl/core/mcst_pulse.sv -----
// two-stage pulse point unit: period * duty / 100
module mcst_pulse (
  input  logic                        clk,
  input  logic [mcst_pkg::CNT_W-1:0]  period,
  input  logic [mcst_pkg::DUTY_W-1:0] duty,
  output logic [mcst_pkg::CNT_W-1:0]  pulse
);
  import mcst_pkg::*;

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;

  // first product, then division by 100 through the reciprocal
  assign prod_nxt = PROD_W'(period) * PROD_W'(duty);
  assign quot_nxt = QUOT_W'(prod_r) * QUOT_W'(RECIP);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
  end

  assign pulse = quot_r[RECIP_SHIFT +: CNT_W];

endmodule

// ----- rtl/core/mcst_cell.sv -----
// one channel cell: channel state, tick update and a stage of the event chain
module mcst_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mcst_pkg::CH_IDX_W-1:0] cell_idx,
  input  mcst_pkg::cell_cmd_t           cmd,
  input  mcst_pkg::ev_t                 ev_in,
  output mcst_pkg::ev_t                 ev_out
);
  import mcst_pkg::*;
  `include "multi_channel_strobe_timer_core_defines.svh"

  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0] per_r, per_nxt;
  logic [CNT_W-1:0] pulse_r, pulse_nxt;
  ev_t              ev_r, ev_nxt;

  logic              sel;
  logic [CHAN_W-1:0] own_chan;
  logic [CNT_W:0]    ph_inc;
  logic [CNT_W-1:0]  ph_wrap;

  assign sel      = CMP_W'(cell_idx) == CMP_W'(cmd.channel);
  assign own_chan = CHAN_W'(CMP_W'(cell_idx));
  assign ph_inc   = {1'b0, phase_r} + (CNT_W+1)'(1);
  assign ph_wrap  = (ph_inc == {1'b0, per_r}) ? '0 : ph_inc[CNT_W-1:0];

  always_comb begin
    rem_nxt   = rem_r;
    phase_nxt = phase_r;
    per_nxt   = per_r;
    pulse_nxt = pulse_r;
    ev_nxt    = ev_r;
    case (cmd.op)
      OP_TICK: begin
        ev_nxt = '0;
        if (rem_r != '0) begin
          rem_nxt = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            // expiry: only the low transfer, no toggle
            phase_nxt = '0;
            per_nxt   = '0;
            ev_nxt    = '{valid: 1'b1, channel: own_chan, kind: KIND_LOW};
          end else begin
            phase_nxt = ph_wrap;
            if (ph_wrap == pulse_r || ph_wrap == '0) begin
              ev_nxt = '{valid: 1'b1, channel: own_chan, kind: KIND_TOGGLE};
            end
          end
        end
      end
      OP_START: begin
        ev_nxt = '0;
        if (sel && rem_r == '0) begin
          rem_nxt   = cmd.duration;
          per_nxt   = cmd.period;
          pulse_nxt = cmd.pulse;
          phase_nxt = '0;
          ev_nxt    = '{valid: 1'b1, channel: own_chan, kind: KIND_HIGH};
        end
      end
      OP_STOP: begin
        ev_nxt = '0;
        if (sel) begin
          rem_nxt = '0;
          per_nxt = '0;
          ev_nxt  = '{valid: 1'b1, channel: own_chan, kind: KIND_LOW};
        end
      end
      OP_SHIFT: begin
        ev_nxt = ev_in;
      end
      default: begin
        ev_nxt = ev_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      phase_r <= '0;
      per_r   <= '0;
      ev_r    <= '0;
    end else begin
      rem_r   <= rem_nxt;
      phase_r <= phase_nxt;
      per_r   <= per_nxt;
      ev_r    <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pulse_r <= pulse_nxt;
  end

  assign ev_out = ev_r;

  // an idle channel has no period, an active one stays inside its period
  `MCST_ASSERT_IMP(a_idle_no_period, rem_r == '0, per_r == '0)
  `MCST_ASSERT_IMP(a_phase_in_period, rem_r != '0, phase_r < per_r)
  `MCST_ASSERT_NXT(a_stop_clears, cmd.op == OP_STOP && sel,
                   rem_r == '0 && ev_r.valid && ev_r.kind == KIND_LOW)

endmodule

// ----- rtl/core/multi_channel_strobe_timer_core.sv -----
// top level of the multi-channel strobe timer
//
// input channel (in_*): one command per transfer. in_tuser carries the mode
// (tick, start, stop); in_tdata carries channel, duration, period and duty.
// start arms an idle channel (duration and period raised to 1, duty capped
// at 100) and gives a high transfer; stop clears a channel and gives low;
// tick updates every channel at once and gives low on expiry or toggle at
// the pulse point and at the period wrap, in channel order.
// result channel (out_*): out_tdata holds the channel, out_tuser the kind,
// out_tlast marks the final result of a command.
// timing: a command is taken in S_IDLE, a start passes the pulse-point
// multiplier in S_MUL and S_DIV, S_EXEC applies the command to all cells,
// then the event chain is shifted CHANNELS times toward cell 0. a shift
// waits while a full output register holds the head of the chain. a stalled
// receiver freezes the chain; no result is dropped. reset clears every
// channel to idle and empties the output.
module multi_channel_strobe_timer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] channel, [17:2] duration, [33:18] period, [40:34] duty, rest zero
  input  logic [mcst_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] mode
  input  logic [mcst_pkg::MODE_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] out_channel, rest zero
  output logic [mcst_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [1:0] transition_kind
  output logic [mcst_pkg::KIND_W-1:0]       out_tuser,
  output logic                              out_tlast
);
  import mcst_pkg::*;
  `include "multi_channel_strobe_timer_core_defines.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DIV   = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  logic [DRN_W-1:0] cnt_r, cnt_nxt;

  // captured command
  mode_t             mode_r;
  logic [CHAN_W-1:0] chan_r;
  logic [CNT_W-1:0]  dur_r;
  logic [CNT_W-1:0]  per_r;
  logic [DUTY_W-1:0] duty_r;

  logic              in_xfer;
  logic [CHAN_W-1:0] in_chan;
  logic [CNT_W-1:0]  in_dur;
  logic [CNT_W-1:0]  in_per;
  logic [DUTY_W-1:0] in_duty;

  logic [CNT_W-1:0]  pulse;
  cell_cmd_t         cmd;
  ev_t               ev [CHANNELS];
  logic [CHANNELS-1:0] ev_valid_vec;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0] out_chan_r;
  kind_t             out_kind_r;
  logic              out_last_r;

  logic out_free;
  logic emit;
  logic can_shift;
  logic more_behind;

  assign in_tready = (st_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_chan   = in_tdata[1:0];
  assign in_dur    = in_tdata[17:2];
  assign in_per    = in_tdata[33:18];
  assign in_duty   = in_tdata[40:34];

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= mode_t'(in_tuser);
      chan_r <= in_chan;
      dur_r  <= (in_dur == '0) ? CNT_W'(1) : in_dur;
      per_r  <= (in_per == '0) ? CNT_W'(1) : in_per;
      duty_r <= (in_duty > DUTY_MAX) ? DUTY_MAX : in_duty;
    end
  end

  mcst_pulse u_pulse (
    .clk    (clk),
    .period (per_r),
    .duty   (duty_r),
    .pulse  (pulse)
  );

  // event chain: cell 0 is the head, the last cell takes an empty slot
  genvar gi;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
      ev_t ev_in_w;
      if (gi == CHANNELS - 1) begin : g_tail
        assign ev_in_w = '0;
      end else begin : g_link
        assign ev_in_w = ev[gi+1];
      end
      mcst_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (CH_IDX_W'(gi)),
        .cmd      (cmd),
        .ev_in    (ev_in_w),
        .ev_out   (ev[gi])
      );
      assign ev_valid_vec[gi] = ev[gi].valid;
    end
  endgenerate

  assign out_free    = !out_valid_r || out_tready;
  assign more_behind = (ev_valid_vec >> 1) != '0;
  assign emit        = (st_r == S_DRAIN) && ev[0].valid && out_free;
  assign can_shift   = (st_r == S_DRAIN) && (!ev[0].valid || out_free);

  // command to all cells
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.channel  = chan_r;
    cmd.duration = dur_r;
    cmd.period   = per_r;
    cmd.pulse    = pulse;
    if (st_r == S_EXEC) begin
      case (mode_r)
        MODE_TICK:  cmd.op = OP_TICK;
        MODE_START: cmd.op = OP_START;
        MODE_STOP:  cmd.op = OP_STOP;
        default:    cmd.op = OP_NONE;
      endcase
    end else if (can_shift) begin
      cmd.op = OP_SHIFT;
    end
  end

  // sequencer
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          st_nxt = (mode_t'(in_tuser) == MODE_START) ? S_MUL : S_EXEC;
        end
      end
      S_MUL: begin
        st_nxt = S_DIV;
      end
      S_DIV: begin
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        st_nxt  = S_DRAIN;
        cnt_nxt = '0;
      end
      S_DRAIN: begin
        if (can_shift) begin
          if (cnt_r == DRN_W'(CHANNELS - 1)) begin
            st_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + DRN_W'(1);
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_chan_r <= ev[0].channel;
      out_kind_r <= ev[0].kind;
      out_last_r <= !more_behind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_chan_r);
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // a held head event must not be shifted away
  `MCST_ASSERT_IMP(a_hold_head, st_r == S_DRAIN && ev[0].valid && !out_free,
                   cmd.op == OP_NONE)
  // the chain is empty whenever a new command can be taken
  `MCST_ASSERT_IMP(a_idle_empty, st_r == S_IDLE, ev_valid_vec == '0)

endmodule
